### rtl/dcfm_pkg.sv
// Package for the drive command frame mixer.
// Holds the transfer payload types, register indexes and byte codes.
// No dependencies.
package dcfm_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned MixW    = 11;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgWatchdogTicks = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLiftDuty      = 1'b1;

  localparam logic [CfgW-1:0] WatchdogTicksRst = 8'd9;
  localparam logic [CfgW-1:0] LiftDutyRst      = 8'd150;

  // Byte codes. The lift commands are axis values 124 and 123, offset by 127.
  localparam logic [ByteW-1:0] SyncByte     = 8'd255;
  localparam logic [ByteW-1:0] LiftUpByte   = 8'd251;
  localparam logic [ByteW-1:0] LiftDownByte = 8'd250;
  localparam logic [ByteW-1:0] DutyClip     = 8'd127;

  // Item kinds carried in the mode field.
  localparam logic ModeByte = 1'b0;
  localparam logic ModeTick = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ByteW-1:0] rx_byte;
    logic             switch_a;
    logic             switch_b;
  } in_item_t;

  typedef struct packed {
    logic             front_fwd;
    logic             front_rev;
    logic             rear_fwd;
    logic             rear_rev;
    logic             lift_up;
    logic             lift_down;
    logic [ByteW-1:0] duty_a;
    logic [ByteW-1:0] duty_b;
    logic             heartbeat;
    logic             frame_done;
  } out_item_t;

  // Bits of the drive line vector.
  typedef struct packed {
    logic lift_down;
    logic lift_up;
    logic rear_rev;
    logic rear_fwd;
    logic front_rev;
    logic front_fwd;
  } lines_t;

  // Duty from a signed mix: twice the magnitude, clipped at 127.
  function automatic logic [ByteW-1:0] mix_duty(input logic signed [MixW-1:0] v);
    logic [MixW-1:0] mag;
    logic [ByteW-1:0] clip;
    mag = v[MixW-1] ? MixW'(-v) : MixW'(v);
    clip = (mag > MixW'(DutyClip)) ? DutyClip : mag[ByteW-1:0];
    return {clip[ByteW-2:0], 1'b0};
  endfunction

endpackage

### rtl/drive_command_frame_mixer_core.sv
// Drive command frame mixer: frame decoding, wheel mixing, lift and watchdog.
// An input transfer reaches its result through the input register, then the result
// register. Throughput: one item per cycle, the result register moves on whenever
// it is empty or its transfer completes.
// Reset (rst_ni low, asynchronous) clears the frame, watchdog and drive state
// and loads the register defaults of 9 watchdog ticks and a lift duty of 150.
// Depends on dcfm_pkg.
module drive_command_frame_mixer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcfm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dcfm_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dcfm_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dcfm_pkg::out_item_t           out_data_o
);
  import dcfm_pkg::*;

  logic [CfgW-1:0]  wd_ticks_q, lift_duty_q;

  logic             in_vld_q;
  in_item_t         in_q;
  logic             out_vld_q;
  out_item_t        out_q;

  logic [1:0]       slot_q, slot_d;
  logic             sync_q, sync_d;
  logic [ByteW-1:0] fb0_q, fb0_d, fb1_q, fb1_d;
  logic [ByteW-1:0] tick_q, tick_d;
  logic             alive_q, alive_d;
  lines_t           lines_q, lines_d;
  logic [ByteW-1:0] duty_a_q, duty_a_d, duty_b_q, duty_b_d;
  logic             hb_q, hb_d;
  logic             done_d;

  logic             adv;
  logic signed [MixW-1:0] lon, lat, rot, front, rear;
  logic             is_up, is_down;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_ticks_q  <= WatchdogTicksRst;
      lift_duty_q <= LiftDutyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWatchdogTicks: wd_ticks_q  <= cfg_wdata_i;
        CfgLiftDuty:      lift_duty_q <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  // Axis decode and right-side mecanum mixes.
  always_comb begin
    lon     = $signed({3'b000, fb0_q}) - $signed(MixW'(DutyClip));
    lat     = $signed({3'b000, fb1_q}) - $signed(MixW'(DutyClip));
    rot     = $signed({3'b000, in_q.rx_byte}) - $signed(MixW'(DutyClip));
    front   = lon - lat - rot;
    rear    = lon + lat - rot;
    is_up   = (fb0_q == LiftUpByte) && (fb1_q == LiftUpByte) &&
              (in_q.rx_byte == LiftUpByte);
    is_down = (fb0_q == LiftDownByte) && (fb1_q == LiftDownByte) &&
              (in_q.rx_byte == LiftDownByte);
  end

  always_comb begin
    slot_d   = slot_q;
    sync_d   = sync_q;
    fb0_d    = fb0_q;
    fb1_d    = fb1_q;
    tick_d   = tick_q;
    alive_d  = alive_q;
    lines_d  = lines_q;
    duty_a_d = duty_a_q;
    duty_b_d = duty_b_q;
    hb_d     = hb_q;
    done_d   = 1'b0;
    if (in_q.mode == ModeTick) begin
      if (tick_q < wd_ticks_q) begin
        tick_d = tick_q + 8'd1;
      end else begin
        tick_d = '0;
        if (!alive_q) lines_d = '0;
        else alive_d = 1'b0;
      end
    end else if (in_q.rx_byte == SyncByte) begin
      sync_d = 1'b1;
      slot_d = 2'd1;
    end else begin
      case (slot_q)
        2'd0: begin
          sync_d = 1'b0;
          slot_d = 2'd1;
        end
        2'd1: begin
          fb0_d  = in_q.rx_byte;
          slot_d = 2'd2;
        end
        2'd2: begin
          fb1_d  = in_q.rx_byte;
          slot_d = 2'd3;
        end
        default: begin
          slot_d = 2'd0;
          if (sync_q) begin
            done_d  = 1'b1;
            hb_d    = !hb_q;
            alive_d = 1'b1;
            lines_d = '0;
            if (is_up) begin
              if (in_q.switch_b) begin
                duty_a_d        = lift_duty_q;
                lines_d.lift_up = 1'b1;
              end
            end else if (is_down) begin
              if (in_q.switch_a) begin
                duty_a_d          = lift_duty_q;
                lines_d.lift_down = 1'b1;
              end
            end else begin
              lines_d.front_rev = front[MixW-1];
              lines_d.front_fwd = !front[MixW-1];
              lines_d.rear_rev  = rear[MixW-1];
              lines_d.rear_fwd  = !rear[MixW-1];
              duty_a_d          = mix_duty(front);
              duty_b_d          = mix_duty(rear);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      slot_q    <= '0;
      sync_q    <= 1'b0;
      fb0_q     <= '0;
      fb1_q     <= '0;
      tick_q    <= '0;
      alive_q   <= 1'b0;
      lines_q   <= '0;
      duty_a_q  <= '0;
      duty_b_q  <= '0;
      hb_q      <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (adv) begin
        out_vld_q <= 1'b1;
        slot_q    <= slot_d;
        sync_q    <= sync_d;
        fb0_q     <= fb0_d;
        fb1_q     <= fb1_d;
        tick_q    <= tick_d;
        alive_q   <= alive_d;
        lines_q   <= lines_d;
        duty_a_q  <= duty_a_d;
        duty_b_q  <= duty_b_d;
        hb_q      <= hb_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_q <= in_data_i;
    if (adv) begin
      out_q.front_fwd  <= lines_d.front_fwd;
      out_q.front_rev  <= lines_d.front_rev;
      out_q.rear_fwd   <= lines_d.rear_fwd;
      out_q.rear_rev   <= lines_d.rear_rev;
      out_q.lift_up    <= lines_d.lift_up;
      out_q.lift_down  <= lines_d.lift_down;
      out_q.duty_a     <= duty_a_d;
      out_q.duty_b     <= duty_b_d;
      out_q.heartbeat  <= hb_d;
      out_q.frame_done <= done_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### rtl/dcfm_checker.sv
// Port-level checks for the drive command frame mixer.
// Bound to drive_command_frame_mixer_core; depends on dcfm_pkg.
module dcfm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input dcfm_pkg::out_item_t  out_data_o
);
  import dcfm_pkg::*;

  logic hb_seen_q;

  // Heartbeat of the last result transfer; it starts low after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hb_seen_q <= 1'b0;
    else if (out_valid_o && !out_stall_i) hb_seen_q <= out_data_o.heartbeat;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with the result register empty");

  a_heartbeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.heartbeat == (hb_seen_q ^ out_data_o.frame_done))
    else $error("heartbeat does not follow completed frames");

  a_frame_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done && !out_data_o.lift_up &&
    !out_data_o.lift_down && (out_data_o.front_fwd || out_data_o.front_rev) |->
    $onehot({out_data_o.front_fwd, out_data_o.front_rev}) &&
    $onehot({out_data_o.rear_fwd, out_data_o.rear_rev}))
    else $error("wheel direction lines inconsistent after a frame");

  a_lift_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.lift_up || out_data_o.lift_down) |->
    $onehot({out_data_o.lift_up, out_data_o.lift_down}) &&
    !out_data_o.front_fwd && !out_data_o.front_rev &&
    !out_data_o.rear_fwd && !out_data_o.rear_rev)
    else $error("lift driven together with wheels or both ways");

endmodule

bind drive_command_frame_mixer_core dcfm_checker u_dcfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### sim/tb_top.sv
// Self-checking bench for drive_command_frame_mixer_core: a stimulus table and framed random
// traffic, checked against a local predictor of frame decoding, mixing, lift and watchdog.
// Depends on dcfm_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcfm_pkg::*;

  localparam int          AxisOffset   = 127;
  localparam int          LiftUpAxis   = 124;
  localparam int          LiftDownAxis = 123;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned MaxReports   = 25;
  localparam int unsigned NumPhases    = 6;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;

  // Predictor copy of the configuration and state.
  logic [7:0] wd_ticks   = WatchdogTicksRst;
  logic [7:0] lift_level = LiftDutyRst;
  logic [1:0] slot_q     = '0;
  logic       sync_q     = 1'b0;
  logic [7:0] axis_q [2] = '{8'd0, 8'd0};
  logic [7:0] tick_cnt   = '0;
  logic       link_up    = 1'b0;
  lines_t     lines_q    = '0;
  logic [7:0] duty_a_q   = '0;
  logic [7:0] duty_b_q   = '0;
  logic       beat_q     = 1'b0;

  stim_row_t   stim_rows[$];
  out_item_t   expected_outputs[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frames_applied = 0;
  int unsigned watchdog_drops = 0;
  int unsigned settings_used = 1;

  drive_command_frame_mixer_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [7:0] wheel_duty(int v);
    int m;
    m = (v < 0) ? -v : v;
    if (m > 127) m = 127;
    return 8'(m * 2);
  endfunction

  // Advances the predicted state by one accepted item and returns the result it produces.
  function automatic out_item_t mixer_predict(in_item_t it);
    out_item_t res;
    int        lon;
    int        lat;
    int        rot;
    int        front;
    int        rear;
    res = '0;
    if (it.mode == ModeTick) begin
      if (tick_cnt < wd_ticks) begin
        tick_cnt = tick_cnt + 8'd1;
      end else begin
        if (!link_up) begin
          if (lines_q != '0) watchdog_drops++;
          lines_q = '0;
        end else begin
          link_up = 1'b0;
        end
        tick_cnt = '0;
      end
    end else if (it.rx_byte == SyncByte) begin
      sync_q = 1'b1;
      slot_q = 2'd1;
    end else begin
      case (slot_q)
        2'd0: begin
          sync_q = 1'b0;
          slot_q = 2'd1;
        end
        2'd1: begin
          axis_q[0] = it.rx_byte;
          slot_q = 2'd2;
        end
        2'd2: begin
          axis_q[1] = it.rx_byte;
          slot_q = 2'd3;
        end
        default: begin
          slot_q = 2'd0;
          if (sync_q) begin
            lon = int'(axis_q[0]) - AxisOffset;
            lat = int'(axis_q[1]) - AxisOffset;
            rot = int'(it.rx_byte) - AxisOffset;
            beat_q = ~beat_q;
            link_up = 1'b1;
            frames_applied++;
            res.frame_done = 1'b1;
            if (lon == LiftUpAxis && lat == LiftUpAxis && rot == LiftUpAxis) begin
              lines_q = '0;
              if (it.switch_b) begin
                duty_a_q = lift_level;
                lines_q.lift_up = 1'b1;
              end
            end else if (lon == LiftDownAxis && lat == LiftDownAxis && rot == LiftDownAxis) begin
              lines_q = '0;
              if (it.switch_a) begin
                duty_a_q = lift_level;
                lines_q.lift_down = 1'b1;
              end
            end else begin
              front = lon - lat - rot;
              rear  = lon + lat - rot;
              lines_q = '0;
              if (front < 0) lines_q.front_rev = 1'b1;
              else lines_q.front_fwd = 1'b1;
              if (rear < 0) lines_q.rear_rev = 1'b1;
              else lines_q.rear_fwd = 1'b1;
              duty_a_q = wheel_duty(front);
              duty_b_q = wheel_duty(rear);
            end
          end
        end
      endcase
    end
    res.front_fwd = lines_q.front_fwd;
    res.front_rev = lines_q.front_rev;
    res.rear_fwd  = lines_q.rear_fwd;
    res.rear_rev  = lines_q.rear_rev;
    res.lift_up   = lines_q.lift_up;
    res.lift_down = lines_q.lift_down;
    res.duty_a    = duty_a_q;
    res.duty_b    = duty_b_q;
    res.heartbeat = beat_q;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic check_result(out_item_t got, out_item_t want);
    if (got.front_fwd !== want.front_fwd) report_mismatch("front_fwd", got.front_fwd, want.front_fwd);
    if (got.front_rev !== want.front_rev) report_mismatch("front_rev", got.front_rev, want.front_rev);
    if (got.rear_fwd !== want.rear_fwd) report_mismatch("rear_fwd", got.rear_fwd, want.rear_fwd);
    if (got.rear_rev !== want.rear_rev) report_mismatch("rear_rev", got.rear_rev, want.rear_rev);
    if (got.lift_up !== want.lift_up) report_mismatch("lift_up", got.lift_up, want.lift_up);
    if (got.lift_down !== want.lift_down) report_mismatch("lift_down", got.lift_down, want.lift_down);
    if (got.duty_a !== want.duty_a) report_mismatch("duty_a", got.duty_a, want.duty_a);
    if (got.duty_b !== want.duty_b) report_mismatch("duty_b", got.duty_b, want.duty_b);
    if (got.heartbeat !== want.heartbeat) report_mismatch("heartbeat", got.heartbeat, want.heartbeat);
    if (got.frame_done !== want.frame_done) begin
      report_mismatch("frame_done", got.frame_done, want.frame_done);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_outputs.size() == 0) begin
        report_mismatch("result with nothing expected", out_data_o, 0);
      end else begin
        check_result(out_data_o, expected_outputs.pop_front());
      end
    end
  end

  function automatic stim_row_t plain_row(logic mode, logic [7:0] rx, logic sw_a, logic sw_b);
    stim_row_t r;
    r.item  = '{mode: mode, rx_byte: rx, switch_a: sw_a, switch_b: sw_b};
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic mode, logic [7:0] rx, logic sw_a, logic sw_b,
                                          out_item_t want);
    stim_row_t r;
    r       = plain_row(mode, rx, sw_a, sw_b);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  task automatic queue_item(logic mode, logic [7:0] rx);
    stim_rows.push_back(plain_row(mode, rx, 1'($urandom), 1'($urandom)));
  endtask

  // Axis bytes never carry the sync code; the extremes come up often.
  function automatic logic [7:0] pick_axis();
    int unsigned p;
    p = $urandom_range(9);
    if (p == 0) return 8'd0;
    if (p == 1) return 8'd254;
    return 8'($urandom_range(254));
  endfunction

  // Mostly complete frames with random content, plus ticks, truncated frames and stray bytes.
  task automatic queue_random_items(int unsigned n);
    int unsigned made;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  code;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_item(ModeByte, SyncByte);
        if ($urandom_range(4) == 0) begin
          code = $urandom_range(1) ? LiftUpByte : LiftDownByte;
          repeat (3) queue_item(ModeByte, code);
        end else begin
          repeat (3) queue_item(ModeByte, pick_axis());
        end
        made += 4;
      end else if (pick < 70) begin
        queue_item(ModeTick, 8'($urandom));
        made += 1;
      end else if (pick < 78) begin
        len = $urandom_range(12, 1);
        repeat (len) queue_item(ModeTick, 8'($urandom));
        made += len;
      end else if (pick < 88) begin
        len = $urandom_range(2, 1);
        queue_item(ModeByte, SyncByte);
        repeat (len) queue_item(ModeByte, pick_axis());
        made += len + 1;
      end else begin
        queue_item(ModeByte, 8'($urandom));
        made += 1;
      end
    end
  endtask

  task automatic send_rows();
    stim_row_t   row;
    int unsigned gap;
    while (stim_rows.size() != 0) begin
      row = stim_rows.pop_front();
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= row.item;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      items_sent++;
      if (row.typed) begin
        void'(mixer_predict(row.item));
        expected_outputs.push_back(row.want);
      end else begin
        expected_outputs.push_back(mixer_predict(row.item));
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // Both registers in back-to-back cycles so the write enable is raised only once.
  task automatic write_registers(logic [7:0] wd, logic [7:0] lift);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgWatchdogTicks;
    cfg_wdata_i <= wd;
    @(posedge clk_i);
    wd_ticks     = wd;
    cfg_idx_i   <= CfgLiftDuty;
    cfg_wdata_i <= lift;
    @(posedge clk_i);
    lift_level   = lift;
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned phase_wd   [NumPhases];
    int unsigned phase_lift [NumPhases];
    int unsigned phase_items[NumPhases];
    phase_wd    = '{9, 0, 255, 2, $urandom_range(15), 9};
    phase_lift  = '{150, 255, 0, $urandom_range(255), $urandom_range(255), 150};
    phase_items = '{115, 150, 150, 150, 140, 140};

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgWatchdogTicks;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Outputs after reset and at the mix extremes are given outright.
    stim_rows.push_back(typed_row(ModeTick, SyncByte, 1'b1, 1'b1, '0));
    stim_rows.push_back(typed_row(ModeByte, SyncByte, 1'b0, 1'b1, '0));
    stim_rows.push_back(typed_row(ModeByte, 8'd254, 1'b1, 1'b0, '0));
    stim_rows.push_back(typed_row(ModeByte, 8'd0, 1'b0, 1'b0, '0));
    stim_rows.push_back(typed_row(ModeByte, 8'd0, 1'b0, 1'b0,
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd254, 8'd254, 1'b1, 1'b1}));
    stim_rows.push_back(plain_row(ModeByte, SyncByte, 1'b1, 1'b1));
    stim_rows.push_back(plain_row(ModeByte, 8'd0, 1'b1, 1'b0));
    stim_rows.push_back(plain_row(ModeByte, 8'd254, 1'b0, 1'b1));
    stim_rows.push_back(typed_row(ModeByte, 8'd254, 1'b1, 1'b1,
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'd254, 8'd254, 1'b0, 1'b1}));
    // Lift up with only its own switch closed, then with only the other one.
    stim_rows.push_back(plain_row(ModeByte, SyncByte, 1'b0, 1'b0));
    stim_rows.push_back(plain_row(ModeByte, LiftUpByte, 1'b0, 1'b0));
    stim_rows.push_back(plain_row(ModeByte, LiftUpByte, 1'b0, 1'b0));
    stim_rows.push_back(typed_row(ModeByte, LiftUpByte, 1'b0, 1'b1,
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, LiftDutyRst, 8'd254, 1'b1, 1'b1}));
    stim_rows.push_back(plain_row(ModeByte, SyncByte, 1'b1, 1'b1));
    stim_rows.push_back(plain_row(ModeByte, LiftUpByte, 1'b1, 1'b1));
    stim_rows.push_back(plain_row(ModeByte, LiftUpByte, 1'b1, 1'b1));
    stim_rows.push_back(plain_row(ModeByte, LiftUpByte, 1'b1, 1'b0));
    stim_rows.push_back(plain_row(ModeByte, SyncByte, 1'b0, 1'b0));
    stim_rows.push_back(plain_row(ModeByte, LiftDownByte, 1'b0, 1'b0));
    stim_rows.push_back(plain_row(ModeByte, LiftDownByte, 1'b0, 1'b0));
    stim_rows.push_back(plain_row(ModeByte, LiftDownByte, 1'b1, 1'b0));
    // A stray byte in slot zero drops the sync mark, so the next frame is not applied.
    stim_rows.push_back(plain_row(ModeByte, 8'd7, 1'b0, 1'b1));
    stim_rows.push_back(plain_row(ModeByte, 8'd100, 1'b1, 1'b0));
    stim_rows.push_back(plain_row(ModeByte, 8'd100, 1'b0, 1'b1));
    stim_rows.push_back(plain_row(ModeByte, 8'd100, 1'b1, 1'b0));

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        while (expected_outputs.size() != 0) @(posedge clk_i);
        repeat (4) @(posedge clk_i);
        write_registers(8'(phase_wd[p]), 8'(phase_lift[p]));
      end
      if (p < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 68;
      end else if (p < 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_random_items(phase_items[p]);
      send_rows();
    end

    while (expected_outputs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d items and checked %0d results over %0d register settings.",
             items_sent, results_seen, settings_used);
    $display("Frames applied: %0d, drive lines dropped by the watchdog: %0d.",
             frames_applied, watchdog_drops);
    if (mismatch_count == 0 && expected_outputs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### drive_command_frame_mixer_core.f
rtl/dcfm_pkg.sv
rtl/drive_command_frame_mixer_core.sv
rtl/dcfm_checker.sv
sim/tb_top.sv
